// ----- design/cmf_pkg.sv -----
// cmf_pkg: shared types, command codes and constants of the message framer
`default_nettype none

package cmf_pkg;

  // result items one command can cause at most
  localparam int NRES = 11;
  localparam int MAX_TOKEN_BYTES = 8;

  // command codes
  localparam logic [3:0] CMD_TYPE      = 4'd0;
  localparam logic [3:0] CMD_CODE      = 4'd1;
  localparam logic [3:0] CMD_ID        = 4'd2;
  localparam logic [3:0] CMD_TOKEN     = 4'd3;
  localparam logic [3:0] CMD_OPTION    = 4'd4;
  localparam logic [3:0] CMD_OPT_UINT  = 4'd5;
  localparam logic [3:0] CMD_PAYLOAD   = 4'd6;
  localparam logic [3:0] CMD_DATA      = 4'd7;
  localparam logic [3:0] CMD_FINISH    = 4'd8;
  localparam logic [3:0] CMD_NEW       = 4'd9;

  // sticky error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STATE = 2'd1;
  localparam logic [1:0] ERR_ARG   = 2'd2;

  // progress flag bit positions
  localparam int F_TYPE    = 0;
  localparam int F_CODE    = 1;
  localparam int F_ID      = 2;
  localparam int F_HEADER  = 3;
  localparam int F_TOKEN   = 4;
  localparam int F_OPTION  = 5;
  localparam int F_PAYLOAD = 6;

  // option header encoding
  localparam logic [16:0] MAX_EXT      = 17'd65804;
  localparam logic [16:0] NIB_DIRECT   = 17'd12;
  localparam logic [16:0] EXT1_LIMIT   = 17'd268;
  localparam logic [16:0] EXT1_BASE    = 17'd13;
  localparam logic [16:0] EXT2_BASE    = 17'd269;
  localparam logic [3:0]  NIB_EXT1     = 4'd13;
  localparam logic [3:0]  NIB_EXT2     = 4'd14;
  localparam logic [7:0]  PAYLOAD_MARK = 8'hff;
  localparam logic [1:0]  COAP_VERSION = 2'd1;
  localparam logic [15:0] COUNT_MAX    = 16'hffff;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] value;
    logic [16:0] option_number;
    logic [16:0] length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic [1:0]  status;
    logic [15:0] total_bytes;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] msg_id;
    logic [6:0]  flags;
    logic [16:0] prev_option;
    logic [1:0]  error_code;
    logic [15:0] byte_count;
  } state_t;

  // bytes of one command, in emit order, with status and running count
  typedef struct packed {
    logic [NRES-1:0][7:0] bytes;
    logic [3:0]           count;
    logic [1:0]           status;
    logic [15:0]          total;
  } result_t;

endpackage

`default_nettype wire

// ----- design/cmf_skid.sv -----
// cmf_skid: two-entry input skid buffer with a registered stall
`default_nettype none

module cmf_skid import cmf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          head_valid,
  output in_item_t      head_item,
  input  wire logic     take
);

  logic     skid_valid;
  in_item_t skid_item;
  logic     in_acc;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;

  // head refills from the skid entry first, then straight from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || take) begin
      if (skid_valid) begin
        head_item  <= skid_item;
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        head_item  <= in_item;
        head_valid <= 1'b1;
      end else begin
        head_valid <= 1'b0;
      end
    end else if (in_acc) begin
      skid_item  <= in_item;
      skid_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- design/cmf_encode.sv -----
// cmf_encode: decodes one command against the message state into its bytes
`default_nettype none

module cmf_encode import cmf_pkg::*; (
  input  wire in_item_t item,
  input  wire state_t   cur,
  output state_t        nxt,
  output result_t       res
);

  // option nibble for a delta or length
  function automatic logic [3:0] nibble(input logic [16:0] v);
    logic [3:0] r;
    if (v <= NIB_DIRECT) r = v[3:0];
    else if (v <= EXT1_LIMIT) r = NIB_EXT1;
    else r = NIB_EXT2;
    return r;
  endfunction

  // number of extension bytes after the option header
  function automatic logic [1:0] ext_len(input logic [16:0] v);
    logic [1:0] r;
    if (v <= NIB_DIRECT) r = 2'd0;
    else if (v <= EXT1_LIMIT) r = 2'd1;
    else r = 2'd2;
    return r;
  endfunction

  // extension bytes, big-endian, right aligned
  function automatic logic [15:0] ext_word(input logic [16:0] v);
    logic [16:0] d;
    if (v <= EXT1_LIMIT) d = v - EXT1_BASE;
    else d = v - EXT2_BASE;
    return d[15:0];
  endfunction

  state_t               s;
  logic [NRES-1:0][7:0] bytes;
  logic [3:0]           n;
  logic                 put_hdr, put_opt, put_val, put_mark, put_data;
  logic [3:0]           tok_len;
  logic [2:0]           sz;
  logic [16:0]          olen;
  logic [16:0]          delta;
  logic [1:0]           dext, lext;
  logic [15:0]          dword, lword;
  logic [16:0]          sum;

  // uint option size and option header fields
  always_comb begin
    if (item.value == 32'd0) sz = 3'd0;
    else if (item.value <= 32'd255) sz = 3'd1;
    else if (item.value <= 32'd65535) sz = 3'd2;
    else sz = 3'd4;
    olen  = (item.command == CMD_OPT_UINT) ? 17'(sz) : item.length;
    delta = item.option_number - cur.prev_option;
    dext  = ext_len(delta);
    lext  = ext_len(olen);
    dword = ext_word(delta);
    lword = ext_word(olen);
  end

  // command decode: checks, state update, which byte groups go out
  always_comb begin
    s        = cur;
    put_hdr  = 1'b0;
    put_opt  = 1'b0;
    put_val  = 1'b0;
    put_mark = 1'b0;
    put_data = 1'b0;
    tok_len  = 4'd0;
    unique case (item.command)
      CMD_TYPE: begin
        if (cur.error_code == ERR_NONE) begin
          if (cur.flags[F_TYPE] || cur.flags[F_HEADER]) s.error_code = ERR_STATE;
          else if (item.value > 32'd3) s.error_code = ERR_ARG;
          else begin
            s.msg_type      = item.value[1:0];
            s.flags[F_TYPE] = 1'b1;
          end
        end
      end
      CMD_CODE: begin
        if (cur.error_code == ERR_NONE) begin
          if (cur.flags[F_CODE] || cur.flags[F_HEADER]) s.error_code = ERR_STATE;
          else if (item.value > 32'd255) s.error_code = ERR_ARG;
          else begin
            s.msg_code      = item.value[7:0];
            s.flags[F_CODE] = 1'b1;
          end
        end
      end
      CMD_ID: begin
        if (cur.error_code == ERR_NONE) begin
          if (cur.flags[F_ID] || cur.flags[F_HEADER]) s.error_code = ERR_STATE;
          else if (item.value > 32'd65535) s.error_code = ERR_ARG;
          else begin
            s.msg_id      = item.value[15:0];
            s.flags[F_ID] = 1'b1;
          end
        end
      end
      CMD_TOKEN: begin
        if (cur.error_code == ERR_NONE) begin
          if (item.length > 17'(MAX_TOKEN_BYTES)) s.error_code = ERR_ARG;
          else if (cur.flags[F_HEADER] || cur.flags[F_TOKEN] || cur.flags[F_OPTION] ||
                   cur.flags[F_PAYLOAD] || !cur.flags[F_TYPE]) s.error_code = ERR_STATE;
          else begin
            put_hdr          = 1'b1;
            tok_len          = item.length[3:0];
            s.flags[F_HEADER] = 1'b1;
            s.flags[F_TOKEN]  = 1'b1;
          end
        end
      end
      CMD_OPTION, CMD_OPT_UINT: begin
        if (cur.error_code == ERR_NONE) begin
          if (olen > MAX_EXT) s.error_code = ERR_ARG;
          else if (item.option_number < cur.prev_option || cur.flags[F_PAYLOAD])
            s.error_code = ERR_STATE;
          else if (delta > MAX_EXT) s.error_code = ERR_ARG;
          else if (!cur.flags[F_HEADER] && !cur.flags[F_TYPE]) s.error_code = ERR_STATE;
          else begin
            put_hdr           = !cur.flags[F_HEADER];
            put_opt           = 1'b1;
            put_val           = (item.command == CMD_OPT_UINT);
            s.flags[F_HEADER] = 1'b1;
            s.flags[F_OPTION] = 1'b1;
            s.prev_option     = item.option_number;
          end
        end
      end
      CMD_PAYLOAD: begin
        if (cur.error_code == ERR_NONE) begin
          if (cur.flags[F_PAYLOAD]) s.error_code = ERR_STATE;
          else if (!cur.flags[F_HEADER] && !cur.flags[F_TYPE]) s.error_code = ERR_STATE;
          else begin
            put_hdr            = !cur.flags[F_HEADER];
            put_mark           = (item.length != 17'd0);
            s.flags[F_HEADER]  = 1'b1;
            s.flags[F_PAYLOAD] = 1'b1;
          end
        end
      end
      CMD_DATA: begin
        put_data = (cur.error_code == ERR_NONE);
      end
      CMD_FINISH: begin
        if (cur.error_code == ERR_NONE && !cur.flags[F_HEADER]) begin
          if (!cur.flags[F_TYPE]) s.error_code = ERR_STATE;
          else begin
            put_hdr           = 1'b1;
            s.flags[F_HEADER] = 1'b1;
          end
        end
      end
      CMD_NEW: begin
        s = '0;
      end
      default: begin
      end
    endcase
  end

  // byte assembly in message order
  always_comb begin
    bytes = '0;
    n     = 4'd0;
    if (put_hdr) begin
      bytes[n] = {COAP_VERSION, cur.msg_type, tok_len}; n = n + 4'd1;
      bytes[n] = cur.msg_code;                          n = n + 4'd1;
      bytes[n] = cur.msg_id[15:8];                      n = n + 4'd1;
      bytes[n] = cur.msg_id[7:0];                       n = n + 4'd1;
    end
    if (put_opt) begin
      bytes[n] = {nibble(delta), nibble(olen)}; n = n + 4'd1;
      if (dext == 2'd2) begin
        bytes[n] = dword[15:8]; n = n + 4'd1;
      end
      if (dext != 2'd0) begin
        bytes[n] = dword[7:0]; n = n + 4'd1;
      end
      if (lext == 2'd2) begin
        bytes[n] = lword[15:8]; n = n + 4'd1;
      end
      if (lext != 2'd0) begin
        bytes[n] = lword[7:0]; n = n + 4'd1;
      end
    end
    if (put_val) begin
      if (sz == 3'd4) begin
        bytes[n] = item.value[31:24]; n = n + 4'd1;
        bytes[n] = item.value[23:16]; n = n + 4'd1;
      end
      if (sz == 3'd4 || sz == 3'd2) begin
        bytes[n] = item.value[15:8]; n = n + 4'd1;
      end
      if (sz != 3'd0) begin
        bytes[n] = item.value[7:0]; n = n + 4'd1;
      end
    end
    if (put_mark) begin
      bytes[n] = PAYLOAD_MARK; n = n + 4'd1;
    end
    if (put_data) begin
      bytes[n] = item.data_byte; n = n + 4'd1;
    end
  end

  // saturating byte count and results
  always_comb begin
    sum            = {1'b0, s.byte_count} + 17'(n);
    nxt            = s;
    nxt.byte_count = sum[16] ? COUNT_MAX : sum[15:0];
    res.bytes      = bytes;
    res.count      = n;
    res.status     = s.error_code;
    res.total      = nxt.byte_count;
  end

endmodule

`default_nettype wire

// ----- design/cmf_emit.sv -----
// cmf_emit: shift register; command bytes go one item a cycle unless stalled
`default_nettype none

module cmf_emit import cmf_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  output logic         ready,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_item
);

  logic [NRES-1:0][7:0] bytes;
  logic [3:0]           rem;
  logic                 has_bytes;
  logic [1:0]           status;
  logic [15:0]          total;
  logic                 out_acc;

  assign out_valid = (rem != 4'd0);
  assign out_acc   = out_valid && !out_stall;
  assign ready     = !out_valid || (out_acc && rem == 4'd1);

  // output item view of the head byte
  always_comb begin
    out_item.out_byte    = bytes[0];
    out_item.byte_valid  = has_bytes;
    out_item.last        = (rem == 4'd1);
    out_item.status      = status;
    out_item.total_bytes = total;
  end

  // load a new command's bytes or shift out one per accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 4'd0;
    end else if (load) begin
      bytes     <= res.bytes;
      rem       <= (res.count == 4'd0) ? 4'd1 : res.count;
      has_bytes <= (res.count != 4'd0);
      status    <= res.status;
      total     <= res.total;
    end else if (out_acc) begin
      bytes <= {8'h00, bytes[NRES-1:1]};
      rem   <= rem - 4'd1;
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= 4'(NRES))
    else $error("emit count above item limit");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || (out_acc && rem == 4'd1)))
    else $error("load while a command is still being sent");
  a_no_byte_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_bytes) |-> rem == 4'd1)
    else $error("empty result is not a single item");
  a_sequence_continues: assert property (@(posedge clk) disable iff (rst)
    (out_acc && rem != 4'd1) |=> (out_valid && rem == $past(rem) - 4'd1))
    else $error("byte sequence broken");
`endif

endmodule

`default_nettype wire

// ----- design/coap_message_framer.sv -----
// coap_message_framer: command-driven CoAP message byte stream encoder
`default_nettype none

// Builds a CoAP message from commands (type, code, id, token start, option start,
// uint option, payload start, data byte, finish, new message) and emits it as
// bytes, one result item per byte, or one item without a byte for a command
// that emits nothing; last marks a command's final item, and every item carries
// the sticky status and the saturating byte count. A command is decoded in the
// cycle it leaves the input skid buffer and its bytes go into an output shift
// register that sends one item per cycle while rsp_stall is low. A command
// thus takes 1 to 11 output items: data bytes and the latching commands
// flow at one item per cycle when not stalled, and a header, option or finish
// command sends one item per byte it emits. The input stall is registered.
module coap_message_framer import cmf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire in_item_t  req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output out_item_t      rsp
);

  logic     head_valid;
  in_item_t head_item;
  logic     emit_ready;
  logic     take;
  state_t   state;
  state_t   state_next;
  result_t  res;

  assign take = head_valid && emit_ready;

  // input skid buffer
  cmf_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req_valid),
    .in_stall   (req_stall),
    .in_item    (req),
    .head_valid (head_valid),
    .head_item  (head_item),
    .take       (take)
  );

  // command decode and byte assembly
  cmf_encode u_encode (
    .item (head_item),
    .cur  (state),
    .nxt  (state_next),
    .res  (res)
  );

  // message state, updated once per command
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  // byte output register
  cmf_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res       (res),
    .ready     (emit_ready),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .out_item  (rsp)
  );

endmodule

`default_nettype wire
